// ===== rtl/double_ended_queue_unit_macros.svh =====
// Assertion shorthands shared by the checker.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned DeqDepthDef = 16;
  localparam int unsigned WordW       = 32;
  localparam int unsigned ReqW        = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned TotalW      = 5;

  localparam logic [ReqW-1:0] ReqPushFront = 3'd0;
  localparam logic [ReqW-1:0] ReqPushBack  = 3'd1;
  localparam logic [ReqW-1:0] ReqPopFront  = 3'd2;
  localparam logic [ReqW-1:0] ReqPopBack   = 3'd3;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  localparam logic signed [WordW-1:0] NoneWord = -32'sd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // take the accepted request
    logic exec;      // update pointers, write store, issue pop read
    logic read;      // capture popped word, read front and rear
    logic load_out;  // fill the output register
  } dp_cmd_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
module deq_ctrl
  import deq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CAPT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.read     = (state_q == S_READ);
    cmd_o.load_out = (state_q == S_CAPT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result or drop the one just taken
      out_valid_q <= cmd_o.load_out || (out_valid_q && !out_ready_i);
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_CAPT;
        end
        S_CAPT: begin
          // hold here until the output register can take the result
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/deq_datapath.sv =====
module deq_datapath
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DeqDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic signed [WordW-1:0]  data_in_i,
  output logic signed [WordW-1:0]  popped_value_o,
  output logic [StatusW-1:0]       status_o,
  output logic signed [WordW-1:0]  front_word_o,
  output logic signed [WordW-1:0]  rear_word_o,
  output logic [TotalW-1:0]        item_total_o,
  output logic                     empty_flag_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = $clog2(2 * DEPTH) + 1;

  function automatic logic [IdxW-1:0] wrap(input logic [SumW-1:0] s);
    logic [SumW-1:0] t;
    t = (s >= SumW'(DEPTH)) ? s - SumW'(DEPTH) : s;
    return t[IdxW-1:0];
  endfunction

  logic signed [WordW-1:0] mem_q [DEPTH];

  logic [ReqW-1:0]         req_q;
  logic signed [WordW-1:0] data_q;
  logic [IdxW-1:0]         front_q;
  logic [CntW-1:0]         count_q;
  logic [StatusW-1:0]      status_q;
  logic                    pop_ok_q;
  logic signed [WordW-1:0] popped_q;
  logic signed [WordW-1:0] rd_a_q;
  logic signed [WordW-1:0] rd_b_q;

  logic signed [WordW-1:0] out_popped_q;
  logic [StatusW-1:0]      out_status_q;
  logic signed [WordW-1:0] out_front_q;
  logic signed [WordW-1:0] out_rear_q;
  logic [TotalW-1:0]       out_total_q;
  logic                    out_empty_q;

  logic                    is_push;
  logic                    is_pop;
  logic                    full;
  logic                    empty;
  logic [IdxW-1:0]         front_dec;
  logic [IdxW-1:0]         front_inc;
  logic [IdxW-1:0]         tail_slot;
  logic [IdxW-1:0]         rear_slot;
  logic [IdxW-1:0]         addr_a;
  logic                    wr_en;
  logic [IdxW-1:0]         wr_addr;
  logic [CntW+TotalW-1:0]  total_ext;

  always_comb begin
    is_push   = (req_q == ReqPushFront) || (req_q == ReqPushBack);
    is_pop    = (req_q == ReqPopFront) || (req_q == ReqPopBack);
    full      = (count_q == CntW'(DEPTH));
    empty     = (count_q == '0);
    front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;
    front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
    tail_slot = wrap(SumW'(front_q) + SumW'(count_q));
    // only meaningful with at least one stored word
    rear_slot = wrap(SumW'(front_q) + SumW'(count_q) - 1'b1);
    // pop back reads the old rear; everything else reads the front
    addr_a    = (cmd_i.exec && (req_q == ReqPopBack)) ? rear_slot : front_q;
    wr_en     = cmd_i.exec && is_push && !full;
    wr_addr   = (req_q == ReqPushFront) ? front_dec : tail_slot;
    total_ext = {{TotalW{1'b0}}, count_q};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= data_q;
    end
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[rear_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      if (is_push && !full) begin
        count_q <= count_q + 1'b1;
        if (req_q == ReqPushFront) begin
          front_q <= front_dec;
        end
      end else if (is_pop && !empty) begin
        count_q <= count_q - 1'b1;
        if (req_q == ReqPopFront) begin
          front_q <= front_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_type_i;
      data_q <= data_in_i;
    end
    if (cmd_i.exec) begin
      pop_ok_q <= is_pop && !empty;
      if (is_push && full) begin
        status_q <= StFull;
      end else if (is_pop && empty) begin
        status_q <= StEmpty;
      end else begin
        status_q <= StOk;
      end
    end
    if (cmd_i.read) begin
      popped_q <= pop_ok_q ? rd_a_q : NoneWord;
    end
    if (cmd_i.load_out) begin
      out_popped_q <= popped_q;
      out_status_q <= status_q;
      out_front_q  <= empty ? NoneWord : rd_a_q;
      out_rear_q   <= empty ? NoneWord : rd_b_q;
      out_total_q  <= total_ext[TotalW-1:0];
      out_empty_q  <= empty;
    end
  end

  assign popped_value_o = out_popped_q;
  assign status_o       = out_status_q;
  assign front_word_o   = out_front_q;
  assign rear_word_o    = out_rear_q;
  assign item_total_o   = out_total_q;
  assign empty_flag_o   = out_empty_q;

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Double-ended queue of signed 32-bit words held in a ring store of DEPTH
// entries, tracked by a front index and a word count. Each input word is a
// request: push front, push back, pop front, pop back or query (codes four to
// seven act as query). Each request gives exactly one result word carrying the
// popped word (-1 when nothing was popped), a status (ok, pop on empty, push on
// full dropped), the front and rear words after the request (-1 when empty),
// the stored count masked to five bits and an empty flag. A push into a full
// queue leaves the queue unchanged. Requests are handled one at a time: a
// request is taken only while the block is idle, its result is loaded into
// the output register after the execute, read and capture states, and the
// next request can be accepted once the block is back in idle. The capture
// state holds while the output register is still full and not taken. The
// popped word is read first from the store, then the new front and rear
// words. A finished result waits in the output register while the next
// request is already taken. The store needs no clearing after reset; words
// are only read once written.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DeqDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ReqW-1:0]         req_type_i,
  input  logic signed [WordW-1:0] data_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [WordW-1:0] popped_value_o,
  output logic [StatusW-1:0]      status_o,
  output logic signed [WordW-1:0] front_word_o,
  output logic signed [WordW-1:0] rear_word_o,
  output logic [TotalW-1:0]       item_total_o,
  output logic                    empty_flag_o
);

  dp_cmd_t cmd;

  // Sequence each request: accept, execute, read, capture.
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold the ring store, pointers and the output register.
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .data_in_i      (data_in_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .front_word_o   (front_word_o),
    .rear_word_o    (rear_word_o),
    .item_total_o   (item_total_o),
    .empty_flag_o   (empty_flag_o)
  );

endmodule

// ===== rtl/deq_checker.sv =====
`include "double_ended_queue_unit_macros.svh"

module deq_checker
  import deq_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [WordW-1:0] popped_value_o,
  input logic [StatusW-1:0]      status_o,
  input logic signed [WordW-1:0] front_word_o,
  input logic signed [WordW-1:0] rear_word_o,
  input logic [TotalW-1:0]       item_total_o,
  input logic                    empty_flag_o
);

  // An empty queue reports no words and a zero count.
  `DEQ_ASSERT(a_empty_consistent, (out_valid_o && empty_flag_o) |-> ((item_total_o == '0) && (front_word_o == NoneWord) && (rear_word_o == NoneWord)), "empty result with words")

  // A dropped push pops nothing and cannot leave the queue empty.
  `DEQ_ASSERT(a_full_drop, (out_valid_o && (status_o == StFull)) |-> ((popped_value_o == NoneWord) && !empty_flag_o), "bad dropped push result")

  // A pop on an empty queue returns -1 and still reports empty.
  `DEQ_ASSERT(a_pop_empty, (out_valid_o && (status_o == StEmpty)) |-> ((popped_value_o == NoneWord) && empty_flag_o), "bad empty pop result")

  // A request in flight blocks the next one.
  `DEQ_ASSERT(a_one_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o, "request accepted back to back")

  // A stalled result word holds.
  `DEQ_ASSERT_ALWAYS(a_out_hold, (rst_ni && out_valid_o && !out_ready_i) |=> (!rst_ni || (out_valid_o && $stable(popped_value_o) && $stable(status_o))), "result dropped or changed while stalled")

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);
